@@ sv/jhcd_pkg.sv @@
package jhcd_pkg;

  localparam int BLOCK_COEFFS = 64;
  localparam logic [5:0] LAST_POS = 6'(BLOCK_COEFFS - 1);
  localparam int MAX_RESULTS = 8;
  localparam logic [7:0] SYM_BAD = 8'hFF;
  localparam logic [7:0] BYTE_FF = 8'hFF;

  // Input item modes
  localparam logic [1:0] MODE_BYTE   = 2'd0;
  localparam logic [1:0] MODE_LOAD   = 2'd1;
  localparam logic [1:0] MODE_RESYNC = 2'd2;

  // Configuration register indexes
  localparam logic CFG_DC_SEL = 1'b0;
  localparam logic CFG_AC_SEL = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  data_byte;
    logic        table_class;
    logic [1:0]  table_id;
    logic [7:0]  entry_slot;
    logic [4:0]  code_length;
    logic [15:0] code_bits;
    logic [7:0]  symbol;
  } in_t;

  typedef struct packed {
    logic [5:0]         coeff_index;
    logic signed [15:0] coeff_value;
    logic [5:0]         zero_run;
    logic               is_dc;
    logic               end_of_block;
    logic               bad_code;
    logic               last;
  } out_t;

  // One code table entry
  typedef struct packed {
    logic [4:0]  len;
    logic [15:0] bits;
    logic [7:0]  sym;
  } ent_t;

  typedef struct packed {
    logic take;   // accept input item
    logic mag;    // consume magnitude bits and emit
    logic srch;   // start table scan
    logic sym;    // act on scan outcome
    logic flush;  // hand held result to output with last set
  } cmd_t;

  typedef struct packed {
    logic is_byte;
    logic await_mag;
    logic mag_ready;
    logic res_full;
    logic can_emit;
    logic out_free;
    logic pend_v;
    logic srch_done;
    logic found;
    logic sym_bad;
  } sts_t;

endpackage

@@ sv/jhcd_ctrl.sv @@
module jhcd_ctrl import jhcd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_STEP   = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_FLUSH  = 3'd4;

  logic [2:0] state_q, state_d;

  // Sequence one input item through symbol decode
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (sts_i.is_byte) state_d = S_STEP;
        end
      end
      S_STEP: begin
        if (sts_i.res_full) begin
          state_d = S_FLUSH;
        end else if (sts_i.await_mag) begin
          if (!sts_i.mag_ready) state_d = S_FLUSH;
          else if (sts_i.can_emit) cmd_o.mag = 1'b1;
        end else begin
          cmd_o.srch = 1'b1;
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (sts_i.srch_done) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts_i.can_emit) begin
          cmd_o.sym = 1'b1;
          state_d = (!sts_i.found || sts_i.sym_bad) ? S_FLUSH : S_STEP;
        end
      end
      S_FLUSH: begin
        if (!sts_i.pend_v) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

endmodule

@@ sv/jhcd_dp.sv @@
module jhcd_dp import jhcd_pkg::*; #(
  parameter int NUM_TABLES = 4,
  parameter int TABLE_ENTRIES = 256,
  parameter int MAX_CODE_LENGTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [1:0] cfg_wdata_i,
  input  in_t        in_data_i,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_data_o
);

  localparam int DEPTH = 2 * NUM_TABLES * TABLE_ENTRIES;
  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(TABLE_ENTRIES + 1);
  localparam int CL = MAX_CODE_LENGTH;
  localparam logic [4:0] LEN_NONE = 5'h1F;

  // Code table store, one region per class and table id
  ent_t mem_q [DEPTH];

  logic [1:0] dc_sel_q, ac_sel_q;
  logic [31:0] buf_q, buf_d;
  logic [5:0] bc_q, bc_d;
  logic aff_q, aff_d;
  logic [6:0] pos_q, pos_d;
  logic [3:0] psz_q, psz_d, prun_q, prun_d;
  logic await_q, await_d;
  logic [3:0] rcnt_q, rcnt_d;
  logic [CL-1:0] win_q, win_d;
  logic [SW-1:0] iss_q, iss_d;
  logic rdv_q;
  ent_t rd_q;
  logic [4:0] blen_q, blen_d;
  logic [7:0] bsym_q, bsym_d;
  out_t pend_q, pend_d, out_q, out_d;
  logic pend_v_q, pend_v_d, out_v_q, out_v_d;

  logic issuing, wr_en, sel_ok, cls, hit, found, out_free, can_emit;
  logic [1:0] sel;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [31:0] w32;
  logic [5:0] shamt;
  logic [CL-1:0] win_top, code_msk;
  logic [5:0] mrest;
  logic [31:0] mv32;
  logic [14:0] mv15, mmask;
  logic mmsb;
  logic signed [16:0] mval17;
  logic [3:0] sym_run, fin_run, fin_size;
  logic signed [15:0] fin_val;
  out_t fin_r, emit_r;
  logic [6:0] fin_pos, q7;
  logic emit_en;
  logic [5:0] crest;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_sel_q <= '0;
      ac_sel_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_DC_SEL) dc_sel_q <= cfg_wdata_i;
      if (cfg_idx_i == CFG_AC_SEL) ac_sel_q <= cfg_wdata_i;
    end
  end

  // Table addressing
  assign cls = (pos_q == '0);
  assign sel = cls ? dc_sel_q : ac_sel_q;
  assign sel_ok = (int'(sel) < NUM_TABLES);
  assign issuing = (int'(iss_q) < TABLE_ENTRIES);
  assign wr_en = cmd_i.take && (in_data_i.mode == MODE_LOAD) &&
                 (int'(in_data_i.table_id) < NUM_TABLES) &&
                 (int'(in_data_i.entry_slot) < TABLE_ENTRIES);
  assign wr_addr = AW'(int'(in_data_i.table_class) * NUM_TABLES * TABLE_ENTRIES +
                       int'(in_data_i.table_id) * TABLE_ENTRIES +
                       int'(in_data_i.entry_slot));
  assign rd_addr = AW'(int'(cls) * NUM_TABLES * TABLE_ENTRIES +
                       int'(sel) * TABLE_ENTRIES + int'(iss_q));

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= '{len: in_data_i.code_length,
                                   bits: in_data_i.code_bits,
                                   sym: in_data_i.symbol};
    if (issuing) rd_q <= mem_q[rd_addr];
  end

  // Compare the fetched entry against the leading buffered bits
  always_comb begin
    shamt = 6'(CL) - {1'b0, rd_q.len};
    win_top = win_q >> shamt;
    code_msk = ~({CL{1'b1}} << rd_q.len);
    hit = rdv_q && sel_ok && (rd_q.len != '0) && (int'(rd_q.len) <= CL) &&
          ({1'b0, rd_q.len} <= bc_q) && (rd_q.len < blen_q) &&
          (win_top == (rd_q.bits[CL-1:0] & code_msk));
  end

  assign found = (blen_q != LEN_NONE);
  assign w32 = buf_q << (6'd32 - bc_q);

  // Magnitude bits and sign extension
  always_comb begin
    mrest = bc_q - {2'b0, psz_q};
    mv32 = buf_q >> mrest;
    mmask = ~(15'h7FFF << psz_q);
    mv15 = mv32[14:0] & mmask;
    mmsb = (psz_q != '0) && ((mv15 & (15'd1 << (psz_q - 4'd1))) != '0);
    if (psz_q == '0 || mmsb) mval17 = {2'b0, mv15};
    else mval17 = $signed({2'b0, mv15}) - $signed({2'b0, mmask});
  end

  // Place a decoded value in the block
  assign sym_run = cls ? 4'd0 : bsym_q[7:4];
  assign fin_run = cmd_i.mag ? prun_q : sym_run;
  assign fin_size = cmd_i.mag ? psz_q : 4'd0;
  assign fin_val = cmd_i.mag ? 16'(mval17) : 16'sd0;

  always_comb begin
    fin_r = '0;
    q7 = pos_q + {3'b0, fin_run};
    fin_pos = pos_q;
    if (pos_q == '0) begin
      fin_r.coeff_value = fin_val;
      fin_r.is_dc = 1'b1;
      fin_pos = 7'd1;
    end else if (fin_size == '0 && fin_run == '0) begin
      fin_r.coeff_index = LAST_POS;
      fin_r.zero_run = LAST_POS - pos_q[5:0];
      fin_r.end_of_block = 1'b1;
      fin_pos = '0;
    end else if (q7 > {1'b0, LAST_POS}) begin
      fin_r.coeff_index = LAST_POS;
      fin_r.zero_run = LAST_POS - pos_q[5:0];
      fin_r.end_of_block = 1'b1;
      fin_r.bad_code = 1'b1;
      fin_pos = '0;
    end else begin
      fin_r.coeff_index = q7[5:0];
      fin_r.coeff_value = fin_val;
      fin_r.zero_run = {2'b0, fin_run};
      if (q7 == {1'b0, LAST_POS}) begin
        fin_r.end_of_block = 1'b1;
        fin_pos = '0;
      end else begin
        fin_pos = q7 + 7'd1;
      end
    end
  end

  assign out_free = !out_v_q || !out_stall_i;
  assign can_emit = !pend_v_q || out_free;

  // Next state of the bit buffer, block position and results
  always_comb begin
    buf_d = buf_q;
    bc_d = bc_q;
    aff_d = aff_q;
    pos_d = pos_q;
    psz_d = psz_q;
    prun_d = prun_q;
    await_d = await_q;
    rcnt_d = rcnt_q;
    win_d = win_q;
    iss_d = issuing ? iss_q + SW'(1) : iss_q;
    blen_d = blen_q;
    bsym_d = bsym_q;
    emit_en = 1'b0;
    emit_r = fin_r;
    crest = bc_q - {1'b0, blen_q};

    // Accept an input item
    if (cmd_i.take) begin
      rcnt_d = '0;
      if (in_data_i.mode == MODE_BYTE) begin
        if (aff_q) begin
          aff_d = 1'b0;
        end else begin
          if (bc_q <= 6'd24) begin
            buf_d = {buf_q[23:0], in_data_i.data_byte};
            bc_d = bc_q + 6'd8;
          end
          if (in_data_i.data_byte == BYTE_FF) aff_d = 1'b1;
        end
      end else if (in_data_i.mode == MODE_RESYNC) begin
        buf_d = '0;
        bc_d = '0;
        aff_d = 1'b0;
        pos_d = '0;
        psz_d = '0;
        prun_d = '0;
        await_d = 1'b0;
      end
    end

    // Consume magnitude bits
    if (cmd_i.mag) begin
      buf_d = buf_q & ~(32'hFFFF_FFFF << mrest);
      bc_d = mrest;
      await_d = 1'b0;
      emit_en = 1'b1;
      pos_d = fin_pos;
    end

    // Start a scan of the selected table
    if (cmd_i.srch) begin
      iss_d = '0;
      blen_d = LEN_NONE;
      win_d = w32[31 -: CL];
    end

    // Keep the shortest match, lowest slot first
    if (hit) begin
      blen_d = rd_q.len;
      bsym_d = rd_q.sym;
    end

    // Act on the scan outcome
    if (cmd_i.sym) begin
      if ((!found && bc_q >= 6'(CL)) || (found && bsym_q == SYM_BAD)) begin
        emit_en = 1'b1;
        emit_r = '0;
        emit_r.is_dc = cls;
        emit_r.end_of_block = 1'b1;
        emit_r.bad_code = 1'b1;
        buf_d = '0;
        bc_d = '0;
        await_d = 1'b0;
        psz_d = '0;
        prun_d = '0;
        pos_d = '0;
      end else if (found) begin
        buf_d = buf_q & ~(32'hFFFF_FFFF << crest);
        bc_d = crest;
        psz_d = bsym_q[3:0];
        prun_d = sym_run;
        if (bsym_q[3:0] != '0) begin
          await_d = 1'b1;
        end else begin
          emit_en = 1'b1;
          pos_d = fin_pos;
        end
      end
    end

    if (emit_en) rcnt_d = rcnt_q + 4'd1;
  end

  // Hold the newest result until it is known whether it is the last
  always_comb begin
    pend_d = pend_q;
    pend_v_d = pend_v_q;
    out_d = out_q;
    out_v_d = out_v_q && out_stall_i;
    if (emit_en) begin
      if (pend_v_q) begin
        out_d = pend_q;
        out_d.last = 1'b0;
        out_v_d = 1'b1;
      end
      pend_d = emit_r;
      pend_v_d = 1'b1;
    end
    if (cmd_i.flush) begin
      out_d = pend_q;
      out_d.last = 1'b1;
      out_v_d = 1'b1;
      pend_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q <= '0;
      bc_q <= '0;
      aff_q <= 1'b0;
      pos_q <= '0;
      psz_q <= '0;
      prun_q <= '0;
      await_q <= 1'b0;
      rcnt_q <= '0;
      iss_q <= SW'(TABLE_ENTRIES);
      rdv_q <= 1'b0;
      blen_q <= LEN_NONE;
      pend_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      buf_q <= buf_d;
      bc_q <= bc_d;
      aff_q <= aff_d;
      pos_q <= pos_d;
      psz_q <= psz_d;
      prun_q <= prun_d;
      await_q <= await_d;
      rcnt_q <= rcnt_d;
      iss_q <= iss_d;
      rdv_q <= issuing;
      blen_q <= blen_d;
      pend_v_q <= pend_v_d;
      out_v_q <= out_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    bsym_q <= bsym_d;
    pend_q <= pend_d;
    out_q <= out_d;
  end

  assign sts_o = '{is_byte:   (in_data_i.mode == MODE_BYTE),
                   await_mag: await_q,
                   mag_ready: (bc_q >= {2'b0, psz_q}),
                   res_full:  (int'(rcnt_q) >= MAX_RESULTS),
                   can_emit:  can_emit,
                   out_free:  out_free,
                   pend_v:    pend_v_q,
                   srch_done: (!issuing && !rdv_q),
                   found:     found,
                   sym_bad:   (bsym_q == SYM_BAD)};

  assign out_valid_o = out_v_q;
  assign out_data_o = out_q;

endmodule

@@ sv/jpeg_huffman_coeff_decoder_top.sv @@
// Channel   Direction  Signals                                  Transfer when
// in        input      in_valid_i, in_stall_o, in_data_i         valid high, stall low
// out       output     out_valid_o, out_stall_i, out_data_o      valid high, stall low
// cfg       input      cfg_we_i, cfg_idx_i, cfg_wdata_i          write enable high
//
// A load, resync or ignored item is taken without stalling the input. A scan byte
// runs one table scan per code word, and usually one more that ends without a
// complete code. Each scan walks every entry of the selected table through the
// single read port; a magnitude field is consumed without a scan.
// Reset clears control state; the code table is not cleared and needs no pass.
// Output stalls hold the block once its held result and output register fill.
module jpeg_huffman_coeff_decoder_top import jhcd_pkg::*; #(
  parameter int NUM_TABLES = 4,
  parameter int TABLE_ENTRIES = 256,
  parameter int MAX_CODE_LENGTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_data_o
);

  cmd_t cmd;
  sts_t sts;

  jhcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  jhcd_dp #(
    .NUM_TABLES      (NUM_TABLES),
    .TABLE_ENTRIES   (TABLE_ENTRIES),
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ sv/jhcd_checker.sv @@
module jhcd_checker import jhcd_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  // A scan byte transfer keeps the block busy, so the input stalls after it
  a_byte_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.mode == MODE_BYTE |=> in_stall_o)
    else $error("scan byte transfer did not stall input");

  // A bad result always closes the block
  a_bad_eob: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_code |-> out_data_o.end_of_block)
    else $error("bad result without end of block");

  // A DC result sits at position zero with no run
  a_dc_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_dc |->
      out_data_o.coeff_index == '0 && out_data_o.zero_run == '0)
    else $error("DC result away from position zero");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind jpeg_huffman_coeff_decoder_top jhcd_checker u_jhcd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

@@ tb/tb.sv @@
module tb import jhcd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 3000;
  localparam int TB_ENTRIES = 16;
  localparam int GEN_TABLES = 2;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_idx_i;
  logic [1:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_stall_o;
  in_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  jpeg_huffman_coeff_decoder_top #(.TABLE_ENTRIES(TB_ENTRIES)) DUT (.*);

  // Decoder state mirror
  logic [4:0] tab_len[2][4][256];
  logic [15:0] tab_bits[2][4][256];
  logic [7:0] tab_sym[2][4][256];
  logic [1:0] dc_sel, ac_sel;
  logic [31:0] bit_buf;
  int bit_cnt, coeff_pos, mag_size, mag_run, step_results;
  bit skip_next, need_mag;

  // Stream builder view of the code tables: symbol per unary code length
  logic [7:0] code_sym[2][4][16];

  in_t byte_q[$];
  out_t coeff_q[$];
  bit stream_bits[$];
  int send_idle, recv_idle, mismatches, cycles;
  logic [1:0] gen_dc, gen_ac;

  // Queue one decoded result
  function automatic void push_coeff(int idx, int val, int run, bit dc, bit eob, bit bad);
    out_t r;
    r.coeff_index = 6'(idx);
    r.coeff_value = 16'(val);
    r.zero_run = 6'(run);
    r.is_dc = dc;
    r.end_of_block = eob;
    r.bad_code = bad;
    r.last = 1'b0;
    coeff_q.push_back(r);
    step_results++;
  endfunction

  function automatic int take_bits(int n);
    int rest;
    longint unsigned v;
    rest = bit_cnt - n;
    v = (64'(bit_buf) >> rest) & ((64'd1 << n) - 1);
    bit_buf = 32'(64'(bit_buf) & ((64'd1 << rest) - 1));
    bit_cnt = rest;
    return int'(v);
  endfunction

  function automatic void drop_block();
    push_coeff(0, 0, 0, coeff_pos == 0, 1'b1, 1'b1);
    bit_buf = '0;
    bit_cnt = 0;
    need_mag = 1'b0;
    mag_size = 0;
    mag_run = 0;
    coeff_pos = 0;
  endfunction

  // Place one value and advance the zigzag position
  function automatic void place_coeff(int run, int size, int val);
    int p;
    p = coeff_pos;
    if (p == 0) begin
      push_coeff(0, val, 0, 1'b1, 1'b0, 1'b0);
      coeff_pos = 1;
    end else if (size == 0 && run == 0) begin
      push_coeff(63, 0, 63 - p, 1'b0, 1'b1, 1'b0);
      coeff_pos = 0;
    end else if (p + run > BLOCK_COEFFS - 1) begin
      push_coeff(63, 0, 63 - p, 1'b0, 1'b1, 1'b1);
      coeff_pos = 0;
    end else begin
      p += run;
      coeff_pos = p + 1;
      if (coeff_pos >= BLOCK_COEFFS) begin
        push_coeff(p, val, run, 1'b0, 1'b1, 1'b0);
        coeff_pos = 0;
      end else begin
        push_coeff(p, val, run, 1'b0, 1'b0, 1'b0);
      end
    end
  endfunction

  // Shortest matching length wins, then the lowest slot
  function automatic bit find_code(output logic [7:0] sym);
    int cls, sel, pre;
    cls = (coeff_pos == 0) ? 1 : 0;
    sel = cls ? dc_sel : ac_sel;
    sym = '0;
    for (int len = 1; len <= 16 && len <= bit_cnt; len++) begin
      pre = int'((64'(bit_buf) >> (bit_cnt - len)) & ((64'd1 << len) - 1));
      for (int s = 0; s < 256; s++) begin
        if (tab_len[cls][sel][s] == len &&
            (int'(tab_bits[cls][sel][s]) & ((1 << len) - 1)) == pre) begin
          sym = tab_sym[cls][sel][s];
          void'(take_bits(len));
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic void decode_coeffs();
    logic [7:0] sym;
    int v, val;
    while (step_results < MAX_RESULTS) begin
      if (need_mag) begin
        if (bit_cnt < mag_size) break;
        v = take_bits(mag_size);
        val = v;
        if (mag_size > 0 && ((v >> (mag_size - 1)) & 1) == 0)
          val = v - ((1 << mag_size) - 1);
        need_mag = 1'b0;
        place_coeff(mag_run, mag_size, val);
      end else begin
        if (!find_code(sym)) begin
          if (bit_cnt >= 16) drop_block();
          break;
        end
        if (sym == SYM_BAD) begin
          drop_block();
          break;
        end
        mag_size = sym[3:0];
        mag_run = (coeff_pos == 0) ? 0 : int'(sym[7:4]);
        if (mag_size > 0) need_mag = 1'b1;
        else place_coeff(mag_run, 0, 0);
      end
    end
  endfunction

  // Work out the results of one accepted item
  function automatic void predict_coeffs(in_t it);
    out_t tail;
    step_results = 0;
    case (it.mode)
      MODE_BYTE: begin
        if (skip_next) begin
          skip_next = 1'b0;
        end else begin
          if (bit_cnt <= 24) begin
            bit_buf = (bit_buf << 8) | 32'(it.data_byte);
            bit_cnt += 8;
          end
          if (it.data_byte == BYTE_FF) skip_next = 1'b1;
        end
        decode_coeffs();
      end
      MODE_LOAD: begin
        tab_len[it.table_class][it.table_id][it.entry_slot] = it.code_length;
        tab_bits[it.table_class][it.table_id][it.entry_slot] = it.code_bits;
        tab_sym[it.table_class][it.table_id][it.entry_slot] = it.symbol;
      end
      MODE_RESYNC: begin
        bit_buf = '0;
        bit_cnt = 0;
        skip_next = 1'b0;
        coeff_pos = 0;
        mag_size = 0;
        mag_run = 0;
        need_mag = 1'b0;
      end
      default: ;
    endcase
    if (step_results > 0) begin
      tail = coeff_q.pop_back();
      tail.last = 1'b1;
      coeff_q.push_back(tail);
    end
  endfunction

  function automatic in_t random_item(logic [1:0] mode);
    in_t it;
    it = in_t'({$urandom, $urandom});
    it.mode = mode;
    return it;
  endfunction

  function automatic void queue_load(int cls, int tid, int slot, int len, int bits, int sym);
    in_t it;
    it = random_item(MODE_LOAD);
    it.table_class = 1'(cls);
    it.table_id = 2'(tid);
    it.entry_slot = 8'(slot);
    it.code_length = 5'(len);
    it.code_bits = 16'(bits);
    it.symbol = 8'(sym);
    byte_q.push_back(it);
  endfunction

  // Entry that can never match: empty or longer than 16 bits
  function automatic void queue_dead_load(int cls, int tid, int slot);
    int len;
    len = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(17, 31);
    queue_load(cls, tid, slot, len, $urandom_range(0, 65535), $urandom_range(0, 255));
  endfunction

  // Unary prefix code per length 1 to 14: L-1 ones then a zero, in shuffled slots.
  // Table 0 adds an oversized entry and a copy of one code in the top slot;
  // table 1 adds a longer code behind a shorter prefix and an empty top slot.
  function automatic void fill_tables();
    int order[TB_ENTRIES];
    int code, sym, pick, j, t;
    for (int cls = 0; cls < 2; cls++) begin
      for (int tid = 0; tid < GEN_TABLES; tid++) begin
        for (int len = 1; len < 15; len++) begin
          if (cls == 1) begin
            case (len)
              1: sym = $urandom_range(0, 15) << 4;
              2: sym = ($urandom_range(0, 15) << 4) | 11;
              14: sym = SYM_BAD;
              default: sym = ($urandom_range(0, 15) << 4) | $urandom_range(0, 11);
            endcase
          end else begin
            case (len)
              1: sym = $urandom_range(1, 14) << 4;
              2: sym = 8'h00;
              3: sym = 8'hF0;
              4: sym = SYM_BAD;
              5: sym = ($urandom_range(0, 15) << 4) | 15;
              default: begin
                sym = $urandom_range(0, 254);
              end
            endcase
          end
          code_sym[cls][tid][len] = 8'(sym);
        end
        // Shuffle the lower slots; the top slot stays for the extra entry
        for (int i = 0; i < TB_ENTRIES - 1; i++) order[i] = i;
        for (int i = TB_ENTRIES - 2; i > 0; i--) begin
          j = $urandom_range(0, i);
          t = order[i];
          order[i] = order[j];
          order[j] = t;
        end
        for (int len = 1; len < 15; len++) begin
          code = ((1 << (len - 1)) - 1) << 1;
          queue_load(cls, tid, order[len - 1], len,
                     code | (($urandom_range(0, 65535) << len) & 16'hFFFF),
                     code_sym[cls][tid][len]);
        end
        pick = $urandom_range(1, 13);
        code = ((1 << (pick - 1)) - 1) << 1;
        if (tid == 0) begin
          queue_load(cls, tid, order[14], $urandom_range(17, 31),
                     $urandom_range(0, 65535), $urandom_range(0, 255));
          // same code at a higher slot loses
          queue_load(cls, tid, TB_ENTRIES - 1, pick, code, $urandom_range(0, 255));
        end else begin
          // longer code sharing a shorter code's prefix loses
          queue_load(cls, tid, order[14], pick + 1, code << 1, $urandom_range(0, 255));
          queue_load(cls, tid, TB_ENTRIES - 1, 0, $urandom_range(0, 65535),
                     $urandom_range(0, 255));
        end
      end
    end
  endfunction

  // Append one code word and its magnitude bits (0 random, 1 all zeros, 2 all ones)
  function automatic int put_code(int cls, int len, int mag_kind);
    logic [7:0] sym;
    int size, bits;
    sym = code_sym[cls][cls ? gen_dc : gen_ac][len];
    for (int i = 1; i < len; i++) stream_bits.push_back(1'b1);
    stream_bits.push_back(1'b0);
    size = sym[3:0];
    bits = mag_kind == 1 ? 0 : mag_kind == 2 ? 32'hFFFF : $urandom;
    for (int i = size - 1; i >= 0; i--) stream_bits.push_back(bits[i]);
    return sym;
  endfunction

  // Pad with ones, pack into bytes with stuffing, then resync if asked
  function automatic void flush_stream(bit resync);
    in_t it;
    while (stream_bits.size() % 8 != 0) stream_bits.push_back(1'b1);
    while (stream_bits.size() > 0) begin
      it = random_item(MODE_BYTE);
      for (int i = 7; i >= 0; i--) it.data_byte[i] = stream_bits.pop_front();
      byte_q.push_back(it);
      if (it.data_byte == BYTE_FF) byte_q.push_back(random_item(MODE_BYTE));
    end
    if (resync) byte_q.push_back(random_item(MODE_RESYNC));
  endfunction

  // One block with random content, possibly cut short by a bad symbol, an early EOB, run overflow or a full block
  function automatic void queue_block();
    int pos, len, nsym;
    logic [7:0] sym;
    void'(put_code(1, $urandom_range(1, 13), $urandom_range(0, 2)));
    pos = 1;
    nsym = $urandom_range(1, 4);
    for (int k = 0; k < nsym; k++) begin
      len = $urandom_range(1, 14);
      if (len == 4 && $urandom_range(0, 3) != 0) len = 6;
      sym = code_sym[0][gen_ac][len];
      void'(put_code(0, len, $urandom_range(0, 2)));
      if (sym == SYM_BAD || sym == 8'h00 || pos + sym[7:4] > 63) begin
        flush_stream(1'b1);
        return;
      end
      pos += sym[7:4] + 1;
      if (pos >= 64) begin
        flush_stream(1'b1);
        return;
      end
    end
    void'(put_code(0, 2, 0));
    flush_stream($urandom_range(0, 3) != 0);
  endfunction

  function automatic void queue_noise();
    case ($urandom_range(0, 3))
      0: byte_q.push_back(random_item(MODE_NONE));
      1: queue_dead_load($urandom_range(0, 1), $urandom_range(2, 3),
                         $urandom_range(0, TB_ENTRIES - 1));
      default: begin
        repeat ($urandom_range(1, 3)) byte_q.push_back(random_item(MODE_BYTE));
        byte_q.push_back(random_item(MODE_RESYNC));
      end
    endcase
  endfunction

  // Wait until every item is taken and every result has come, then settle
  task automatic drain();
    while (byte_q.size() > 0 || in_valid_i || coeff_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_sel(logic idx, logic [1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    if (idx == CFG_DC_SEL) dc_sel = val;
    else ac_sel = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Driver: offer the next item unless idling, hold it while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) predict_coeffs(in_data_i);
      if (!in_valid_i || !in_stall_o) begin
        if (byte_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          in_valid_i <= 1'b1;
          in_data_i <= byte_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= $urandom_range(0, 99) < recv_idle;
      if (out_valid_o && !out_stall_i) begin
        if (coeff_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data_o);
        end else begin
          out_t want;
          want = coeff_q.pop_front();
          if (out_data_o !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("expected %p got %p", want, out_data_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [1:0] dc_plan[6];
    logic [1:0] ac_plan[6];
    dc_plan = '{2'd0, 2'd1, 2'd1, 2'd0, 2'd0, 2'd1};
    ac_plan = '{2'd0, 2'd1, 2'd0, 2'd1, 2'd1, 2'd0};
    mismatches = 0;
    cycles = 0;
    send_idle = 12;
    recv_idle = 64;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_DC_SEL;
    cfg_wdata_i = '0;
    dc_sel = '0;
    ac_sel = '0;
    bit_buf = '0;
    bit_cnt = 0;
    coeff_pos = 0;
    mag_size = 0;
    mag_run = 0;
    skip_next = 1'b0;
    need_mag = 1'b0;
    gen_dc = '0;
    gen_ac = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Load every entry of every selected table before any scan data
    fill_tables();
    drain();

    // Directed: magnitude extremes, a zero-size AC run, EOB
    void'(put_code(1, 2, 1));
    void'(put_code(0, 5, 2));
    void'(put_code(0, 1, 0));
    void'(put_code(0, 2, 0));
    flush_stream(1'b1);
    // Repeated ZRL until the run overflows
    void'(put_code(1, 1, 0));
    repeat (4) void'(put_code(0, 3, 0));
    flush_stream(1'b1);
    // No matching code
    repeat (16) stream_bits.push_back(1'b1);
    flush_stream(1'b1);
    // Bad symbol, then a byte holding eight codes
    void'(put_code(1, 3, 0));
    void'(put_code(0, 4, 0));
    flush_stream(1'b1);
    void'(put_code(1, 1, 0));
    repeat (10) void'(put_code(0, 1, 0));
    void'(put_code(0, 2, 0));
    flush_stream(1'b1);
    byte_q.push_back(random_item(MODE_NONE));
    queue_dead_load(0, 3, TB_ENTRIES - 1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        send_idle = 64;
        recv_idle = 12;
      end else if (ph == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_sel(CFG_DC_SEL, dc_plan[ph]);
      write_sel(CFG_AC_SEL, ac_plan[ph]);
      gen_dc = dc_plan[ph];
      gen_ac = ac_plan[ph];
      repeat (2) begin
        queue_block();
        if ($urandom_range(0, 2) == 0) queue_noise();
      end
      drain();
    end

    if (mismatches == 0 && coeff_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
